// ===== rtl/sliding_window_maximum_unit_macros.svh =====
// Assertion macros for the sliding window maximum unit checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SWM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
// Shared types and constants of the sliding window maximum unit.
// No dependencies; every other file but swm_ram and the macro header refers to this package by scoped names.
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 32;

   // window_size register
   localparam int                    CFG_WIDTH         = 7;
   localparam logic [CFG_WIDTH-1:0]  WINDOW_SIZE_RESET = 7'd3;

   // configuration port
   localparam int                        CSR_ADDR_WIDTH  = 3;
   localparam int                        CSR_DATA_WIDTH  = 32;
   localparam int                        CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_SIZE = 1'b0;

   // queue memory read address select
   typedef enum logic [1:0] {
      RD_PREV_TAIL,
      RD_PREV2_TAIL,
      RD_HEAD,
      RD_NEW_HEAD
   } rd_sel_type;

   typedef struct packed {
      logic       accept;        // latch the sample, clear on sequence start
      logic       start;
      logic       trim_back;     // drop the entry at the back
      logic       front_append;  // expire front, append sample, advance counters
      logic       load_out;      // load the result register
      logic       rd_en;
      rd_sel_type rd_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic occ_zero;
      logic occ_one;
      logic back_drop;   // back entry is not greater than the sample
      logic emit;        // the sample being appended produces a result
   } dp_status_type;

endpackage

// ===== rtl/swm_req_if.sv =====
// Input channel of the sliding window maximum unit: valid/ready plus sample fields.
// Depends on swm_pkg for the default sample width.
interface swm_req_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           starts_sequence;

   modport source (output valid, output sample, output starts_sequence, input ready);
   modport sink (input valid, input sample, input starts_sequence, output ready);
   modport monitor (input valid, input sample, input starts_sequence, input ready);
endinterface

// ===== rtl/swm_rsp_if.sv =====
// Result channel of the sliding window maximum unit: valid/ready plus window_max.
// Depends on swm_pkg for the default sample width.
interface swm_rsp_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink (input valid, input window_max, output ready);
   modport monitor (input valid, input window_max, input ready);
endinterface

// ===== rtl/swm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/swm_ctrl.sv =====
// Controller of the sliding window maximum unit: sequences back pops,
// front expiry with append, and result hand-off. Depends on swm_pkg.
module swm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_start,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swm_pkg::dp_cmd_type   cmd,
   input  swm_pkg::dp_status_type status
);
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BACK,
      ST_FRONT_APPEND
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      load         = (state_ff == ST_IDLE) && pend_ff && out_free;
      req_ready    = (state_ff == ST_IDLE) && (!pend_ff || out_free);
      state_in     = state_ff;
      pend_in      = load ? 1'b0 : pend_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      cmd          = '0;
      cmd.rd_sel   = swm_pkg::RD_HEAD;
      cmd.load_out = load;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               cmd.start  = req_start;
               if (!req_start && !status.occ_zero) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = swm_pkg::RD_PREV_TAIL;
                  state_in   = ST_BACK;
               end else begin
                  state_in = ST_FRONT_APPEND;
               end
            end
         end
         ST_BACK: begin
            if (status.back_drop) begin
               cmd.trim_back = 1'b1;
               if (!status.occ_one) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = swm_pkg::RD_PREV2_TAIL;
               end else begin
                  state_in = ST_FRONT_APPEND;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = swm_pkg::RD_HEAD;
               state_in   = ST_FRONT_APPEND;
            end
         end
         ST_FRONT_APPEND: begin
            cmd.front_append = 1'b1;
            cmd.rd_en        = 1'b1;
            cmd.rd_sel       = swm_pkg::RD_NEW_HEAD;
            pend_in          = status.emit;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== rtl/swm_dpath.sv =====
// Datapath of the sliding window maximum unit: monotonic queue in RAM,
// ring pointers, position and sample counters, result register.
// Depends on swm_pkg and swm_ram.
module swm_dpath #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swm_pkg::dp_cmd_type                 cmd,
   output swm_pkg::dp_status_type              status,
   input  logic [swm_pkg::CFG_WIDTH-1:0]       win,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_window_max
);
   localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int OCC_W   = $clog2(WINDOW_MAX + 1);
   localparam int POS_MOD = 2 * WINDOW_MAX;
   localparam int POS_W   = $clog2(POS_MOD);
   localparam int CW      = swm_pkg::CFG_WIDTH;
   localparam int CMP_W   = (POS_W > CW) ? POS_W : CW;
   localparam int ENTRY_W = SAMPLE_WIDTH + POS_W;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(WINDOW_MAX - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(WINDOW_MAX - 1) : i - 1'b1;
   endfunction

   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic [IDX_W-1:0]               head_ff, head_in;
   logic [IDX_W-1:0]               tail_ff, tail_in;
   logic [OCC_W-1:0]               occ_ff, occ_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [CW-1:0]                  seen_ff, seen_in;

   logic [ENTRY_W-1:0]             rdata;
   logic [IDX_W-1:0]               raddr;
   logic signed [SAMPLE_WIDTH-1:0] rd_value;
   logic [POS_W-1:0]               rd_pos;
   logic [POS_W:0]                 age_wide;
   logic                           drop_front;
   logic                           overflow;
   logic [IDX_W-1:0]               head1, head2;
   logic [OCC_W-1:0]               occ1, occ2;
   logic [POS_W-1:0]               pos_next;
   logic [CW-1:0]                  seen_next;

   assign rd_value = rdata[ENTRY_W-1:POS_W];
   assign rd_pos   = rdata[POS_W-1:0];

   // front expiry, overflow and append bookkeeping
   always_comb begin
      if (pos_ff >= rd_pos) begin
         age_wide = {1'b0, pos_ff} - {1'b0, rd_pos};
      end else begin
         age_wide = {1'b0, pos_ff} + (POS_W + 1)'(POS_MOD) - {1'b0, rd_pos};
      end
      drop_front = (occ_ff != '0) && (CMP_W'(age_wide[POS_W-1:0]) >= CMP_W'(win));
      head1      = drop_front ? idx_next(head_ff) : head_ff;
      occ1       = occ_ff - OCC_W'(drop_front);
      overflow   = (occ1 == OCC_W'(WINDOW_MAX));
      head2      = overflow ? idx_next(head1) : head1;
      occ2       = occ1 - OCC_W'(overflow);
      pos_next   = (pos_ff == POS_W'(POS_MOD - 1)) ? '0 : pos_ff + 1'b1;
      seen_next  = (seen_ff < win) ? seen_ff + 1'b1 : win;
   end

   always_comb begin
      case (cmd.rd_sel)
         swm_pkg::RD_PREV_TAIL:  raddr = idx_prev(tail_ff);
         swm_pkg::RD_PREV2_TAIL: raddr = idx_prev(idx_prev(tail_ff));
         swm_pkg::RD_HEAD:       raddr = head_ff;
         swm_pkg::RD_NEW_HEAD:   raddr = head2;
         default:                raddr = head_ff;
      endcase
   end

   always_comb begin
      status.occ_zero  = (occ_ff == '0);
      status.occ_one   = (occ_ff == OCC_W'(1));
      status.back_drop = !(rd_value > sample_ff);
      status.emit      = (win != '0) && (seen_next == win);
   end

   always_comb begin
      sample_in = sample_ff;
      out_in    = out_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      // a lone entry is the sample just appended, not yet readable
      if (cmd.load_out) begin
         out_in = status.occ_one ? sample_ff : rd_value;
      end
      if (cmd.accept) begin
         sample_in = req_sample;
         if (cmd.start) begin
            head_in = '0;
            tail_in = '0;
            occ_in  = '0;
            pos_in  = '0;
            seen_in = '0;
         end
      end
      if (cmd.trim_back) begin
         tail_in = idx_prev(tail_ff);
         occ_in  = occ_ff - 1'b1;
      end
      if (cmd.front_append) begin
         head_in = head2;
         tail_in = idx_next(tail_ff);
         occ_in  = occ2 + 1'b1;
         pos_in  = pos_next;
         seen_in = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      out_ff    <= out_in;
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         pos_ff  <= '0;
         seen_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
   end

   swm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_MAX)
   ) u_queue_ram (
      .clock (clock),
      .we    (cmd.front_append),
      .waddr (tail_ff),
      .wdata ({sample_ff, pos_ff}),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_window_max = out_ff;
endmodule

// ===== rtl/sliding_window_maximum_unit.sv =====
// Sliding window maximum unit: running maximum of the last window_size samples.
// Per transfer: accept, back-queue compares (none on an empty queue or a sequence start,
// else one per entry dropped from the back plus a stopping compare unless they empty it),
// front expiry with append. rsp valid rises when the result is loaded; the next input transfer can
// share that edge, but an unread result still in the output register holds input and result.
// Sync reset empties the queue and sets window_size to 3. Uses swm_pkg and all rtl modules but swm_checker.
module sliding_window_maximum_unit #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   swm_req_if.sink                              req_chan,
   swm_rsp_if.source                            rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [swm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [swm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [swm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   localparam int CW = swm_pkg::CFG_WIDTH;

   logic [CW-1:0]                          window_size_ff, window_size_in;
   logic [CW-1:0]                          win;
   logic [swm_pkg::CSR_INDEX_WIDTH-1:0]    reg_idx;
   logic                                   csr_write;
   swm_pkg::dp_cmd_type                    cmd;
   swm_pkg::dp_status_type                 status;

   // Configuration: one register, window_size, at byte address 0.
   // Writes complete in the access phase; the port never stalls.
   assign pready    = 1'b1;
   assign reg_idx   = paddr[swm_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      window_size_in = window_size_ff;
      prdata         = '0;
      unique case (reg_idx)
         swm_pkg::REG_WINDOW_SIZE: begin
            prdata = swm_pkg::CSR_DATA_WIDTH'(window_size_ff);
            if (csr_write) begin
               window_size_in = pwdata[CW-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WINDOW_SIZE_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   // Clamp the window to the queue capacity.
   assign win = (int'(window_size_ff) > WINDOW_MAX) ? CW'(WINDOW_MAX) : window_size_ff;

   // Controller: accept, walk the back of the queue, expire and append,
   // then hand the result to the output register, which can coincide with taking the next sample.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_start (req_chan.starts_sequence),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: queue memory of (value, position) pairs and its pointers.
   swm_dpath #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .win            (win),
      .req_sample     (req_chan.sample),
      .rsp_window_max (rsp_chan.window_max)
   );
endmodule

// ===== rtl/swm_checker.sv =====
// Port-level checks of the sliding window maximum unit, bound to the top level.
// Depends on sliding_window_maximum_unit_macros.svh and swm_pkg.
`include "sliding_window_maximum_unit_macros.svh"

module swm_checker #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_window_max
);
   `SWM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped")
   `SWM_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_window_max), "rsp changed")
   `SWM_ASSERT(a_busy_after_take, req_valid && req_ready |=> !req_ready, "input taken twice")
   `SWM_ASSERT(a_result_from_idle, $rose(rsp_valid) |-> $past(req_ready), "result while busy")
   `SWM_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "rsp valid set after reset")
endmodule

bind sliding_window_maximum_unit swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_window_max (rsp_chan.window_max)
);
